// File: rtl/core/ptf_pkg.sv
// Package for the page translation core: widths, limits, register indexes,
// config reset values and the controller/datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps

package ptf_pkg;

    localparam int VA_W       = 20;
    localparam int MAX_PAGES  = 4096;
    localparam int MAX_FRAMES = 256;
    localparam int PAGE_W     = $clog2(MAX_PAGES);
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int FCNT_W     = FRAME_W + 1;
    localparam int PB_W       = 4;
    localparam int VB_W       = 5;
    localparam int PHB_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int CNT_W      = 32;

    // Stream payload widths, padded to whole bytes
    localparam int S_DATA_W   = ((VA_W + 7) / 8) * 8;
    localparam int M_RAW_W    = VA_W + PAGE_W + FRAME_W + PAGE_W + 2 * CNT_W;
    localparam int M_DATA_W   = ((M_RAW_W + 7) / 8) * 8;
    localparam int M_USER_W   = 3;

    // Clamp limits
    localparam logic [PB_W-1:0]  PB_MIN  = PB_W'(1);
    localparam logic [PB_W-1:0]  PB_MAX  = PB_W'(12);
    localparam logic [VB_W-1:0]  VB_MIN  = VB_W'(2);
    localparam logic [VB_W-1:0]  VB_MAX  = VB_W'(20);
    localparam logic [PHB_W-1:0] PHB_MIN = PHB_W'(1);
    localparam logic [PHB_W-1:0] PHB_MAX = PHB_W'(20);

    // Register reset values
    localparam logic [PB_W-1:0]  PB_RST  = PB_W'(8);
    localparam logic [VB_W-1:0]  VB_RST  = VB_W'(16);
    localparam logic [PHB_W-1:0] PHB_RST = PHB_W'(12);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BITS     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_VIRTUAL_BITS  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_PHYSICAL_BITS = CFG_IDX_W'(2);

    typedef struct packed {
        logic clear_en;  // sweep one page table entry to invalid
        logic accept;    // take an input beat, start table reads
        logic resolve;   // finish a hit, a plain miss or a range error
        logic evict;     // invalidate the victim's old mapping
        logic commit;    // finish a miss that evicted
    } ptf_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic out_free;
        logic need_evict;
    } ptf_status_t;

endpackage

// File: rtl/core/ptf_ctrl.sv
// Controller FSM for the page translation core: table clear sweep, accept,
// lookup and eviction sequencing. Depends on ptf_pkg.
`timescale 1ns / 1ps

module ptf_ctrl import ptf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  ptf_status_t status,
    output ptf_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_LOOKUP = 4'b0100,
        S_UPDATE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (status.clear_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (status.need_evict) begin
                    cmd.evict  = 1'b1;
                    state_next = S_UPDATE;
                end else if (status.out_free) begin
                    cmd.resolve = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_UPDATE: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// File: rtl/core/ptf_datapath.sv
// Datapath for the page translation core: config registers, page table and
// frame owner memories, FIFO replacement pointers, counters, result register.
// Depends on ptf_pkg.
`timescale 1ns / 1ps

module ptf_datapath import ptf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [VA_W-1:0]       in_va,
    input  ptf_cmd_t              cmd,
    output ptf_status_t           status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VA_W-1:0]       out_pa,
    output logic [PAGE_W-1:0]     out_page,
    output logic [FRAME_W-1:0]    out_frame,
    output logic                  out_hit,
    output logic                  out_replaced,
    output logic [PAGE_W-1:0]     out_evicted,
    output logic                  out_err,
    output logic [CNT_W-1:0]      out_hits,
    output logic [CNT_W-1:0]      out_misses
);

    // Config registers
    logic [PB_W-1:0]  page_bits_reg;
    logic [VB_W-1:0]  virt_bits_reg;
    logic [PHB_W-1:0] phys_bits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_bits_reg <= PB_RST;
            virt_bits_reg <= VB_RST;
            phys_bits_reg <= PHB_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PAGE_BITS:     page_bits_reg <= cfg_wdata[PB_W-1:0];
                CFG_VIRTUAL_BITS:  virt_bits_reg <= cfg_wdata[VB_W-1:0];
                CFG_PHYSICAL_BITS: phys_bits_reg <= cfg_wdata[PHB_W-1:0];
                default: ;
            endcase
        end
    end

    // Accept-side decode from live config
    logic [PB_W-1:0]  pb;
    logic [VB_W-1:0]  vb;
    logic [PHB_W-1:0] phb;
    logic [PHB_W-1:0] fdiff;
    logic [FCNT_W-1:0] frames;
    logic [VA_W-1:0]  page_full;
    logic [VA_W-1:0]  offset;
    logic             range_err;
    logic [FRAME_W-1:0] victim;

    // Sequential state
    logic [FRAME_W-1:0] oldest_reg;
    logic [FCNT_W-1:0]  frames_used_reg;
    logic [CNT_W-1:0]   hits_reg;
    logic [CNT_W-1:0]   misses_reg;
    logic [PAGE_W-1:0]  clear_cnt_reg;

    always_comb begin
        if (page_bits_reg < PB_MIN)      pb = PB_MIN;
        else if (page_bits_reg > PB_MAX) pb = PB_MAX;
        else                             pb = page_bits_reg;
        if (virt_bits_reg < VB_MIN)      vb = VB_MIN;
        else if (virt_bits_reg > VB_MAX) vb = VB_MAX;
        else                             vb = virt_bits_reg;
        if (phys_bits_reg < PHB_MIN)      phb = PHB_MIN;
        else if (phys_bits_reg > PHB_MAX) phb = PHB_MAX;
        else                              phb = phys_bits_reg;

        fdiff = phb - PHB_W'(pb);
        if (phb <= PHB_W'(pb))                   frames = FCNT_W'(1);
        else if (fdiff >= PHB_W'(FRAME_W))       frames = FCNT_W'(MAX_FRAMES);
        else frames = FCNT_W'(1) << fdiff[$clog2(FRAME_W)-1:0];

        page_full = in_va >> pb;
        offset    = in_va & ((VA_W'(1) << pb) - VA_W'(1));
        // Page count cap only bites above the table size
        range_err = ((in_va >> vb) != '0) || (page_full[VA_W-1:PAGE_W] != '0);

        victim = ({1'b0, oldest_reg} >= frames) ? '0 : oldest_reg;
    end

    // Per-item registers
    logic                err_reg;
    logic [PAGE_W-1:0]   page_reg;
    logic [VA_W-1:0]     offset_reg;
    logic [PB_W-1:0]     pb_reg;
    logic [FCNT_W-1:0]   frames_reg;
    logic [FRAME_W-1:0]  victim_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            err_reg    <= range_err;
            page_reg   <= page_full[PAGE_W-1:0];
            offset_reg <= offset;
            pb_reg     <= pb;
            frames_reg <= frames;
            victim_reg <= victim;
        end
    end

    // Page table: valid bit over frame number
    logic [FRAME_W:0] page_map [MAX_PAGES];
    logic [FRAME_W:0] map_rd_reg;
    logic [PAGE_W-1:0] owner [MAX_FRAMES];
    logic [PAGE_W-1:0] owner_rd_reg;

    logic              map_we;
    logic [PAGE_W-1:0] map_waddr;
    logic [FRAME_W:0]  map_wdata;
    logic              owner_we;
    logic [FRAME_W-1:0] owner_waddr;

    logic               is_hit;
    logic               plain_miss;
    logic [FRAME_W-1:0] new_frame;

    assign is_hit     = map_rd_reg[FRAME_W];
    assign plain_miss = cmd.resolve && !err_reg && !is_hit;
    assign new_frame  = cmd.commit ? victim_reg : frames_used_reg[FRAME_W-1:0];

    always_comb begin
        map_we      = 1'b0;
        map_waddr   = page_reg;
        map_wdata   = {1'b1, new_frame};
        owner_we    = plain_miss || cmd.commit;
        owner_waddr = new_frame;
        priority if (cmd.clear_en) begin
            map_we    = 1'b1;
            map_waddr = clear_cnt_reg;
            map_wdata = '0;
        end else if (cmd.evict) begin
            map_we    = 1'b1;
            map_waddr = owner_rd_reg;
            map_wdata = '0;
        end else if (plain_miss || cmd.commit) begin
            map_we    = 1'b1;
        end else begin
            map_we    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (map_we) begin
            page_map[map_waddr] <= map_wdata;
        end
        if (cmd.accept) begin
            map_rd_reg <= page_map[page_full[PAGE_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (owner_we) begin
            owner[owner_waddr] <= page_reg;
        end
        if (cmd.accept) begin
            owner_rd_reg <= owner[victim];
        end
    end

    // Replacement pointers, counters, clear sweep
    logic [FCNT_W-1:0] victim_inc;
    assign victim_inc = {1'b0, victim_reg} + FCNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg      <= '0;
            frames_used_reg <= '0;
            hits_reg        <= '0;
            misses_reg      <= '0;
            clear_cnt_reg   <= '0;
        end else begin
            if (cmd.clear_en) begin
                clear_cnt_reg <= clear_cnt_reg + PAGE_W'(1);
            end
            if (cmd.resolve && !err_reg && is_hit) begin
                hits_reg <= hits_reg + CNT_W'(1);
            end
            if (plain_miss || cmd.commit) begin
                misses_reg <= misses_reg + CNT_W'(1);
            end
            if (plain_miss) begin
                frames_used_reg <= frames_used_reg + FCNT_W'(1);
            end
            if (cmd.commit) begin
                oldest_reg <= (victim_inc >= frames_reg) ? '0 : victim_inc[FRAME_W-1:0];
            end
        end
    end

    // Result register
    logic               out_valid_reg;
    logic [FRAME_W-1:0] res_frame;

    assign res_frame = cmd.commit ? victim_reg :
                       (is_hit ? map_rd_reg[FRAME_W-1:0] : frames_used_reg[FRAME_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.resolve || cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.resolve || cmd.commit) begin
            out_err     <= cmd.resolve && err_reg;
            out_hits    <= (cmd.resolve && !err_reg && is_hit) ? hits_reg + CNT_W'(1)
                                                                : hits_reg;
            out_misses  <= (plain_miss || cmd.commit) ? misses_reg + CNT_W'(1) : misses_reg;
            if (cmd.resolve && err_reg) begin
                out_pa       <= '0;
                out_page     <= '0;
                out_frame    <= '0;
                out_hit      <= 1'b0;
                out_replaced <= 1'b0;
                out_evicted  <= '0;
            end else begin
                out_pa       <= ({{(VA_W-FRAME_W){1'b0}}, res_frame} << pb_reg) | offset_reg;
                out_page     <= page_reg;
                out_frame    <= res_frame;
                out_hit      <= cmd.resolve && is_hit;
                out_replaced <= cmd.commit;
                out_evicted  <= cmd.commit ? owner_rd_reg : '0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.clear_done = (clear_cnt_reg == PAGE_W'(MAX_PAGES - 1));
    assign status.need_evict = !err_reg && !is_hit && (frames_used_reg >= frames_reg);

`ifndef SYNTHESIS
    a_frames_used_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        frames_used_reg <= FCNT_W'(MAX_FRAMES))
        else $error("frames_used beyond frame limit");

    a_no_result_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.resolve || cmd.commit) |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending beat");

    a_evict_needs_frames: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.evict |-> (frames_used_reg != '0))
        else $error("eviction with no frame handed out");
`endif

endmodule

// File: rtl/core/page_translate_fifo_replace_core.sv
// S_IDLE accepts a beat and starts table reads; S_LOOKUP loads the result on a hit, a
// plain miss or a range error, or invalidates the victim's old mapping on a miss that
// evicts, and S_UPDATE then loads the result. Result loads wait for a free output
// register; one item in flight. Reset: synchronous, active low; afterwards a sweep
// invalidates all 4096 page table entries with s_tready low. Config writes are taken
// at any time. Top level; instantiates ptf_ctrl and ptf_datapath, depends on ptf_pkg.
`timescale 1ns / 1ps

module page_translate_fifo_replace_core import ptf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // virtual_address
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // physical_address, page_number, frame_number, evicted_page, hit_count, miss_count
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic [M_USER_W-1:0]   m_tuser    // hit, replaced, range_error
);

    ptf_cmd_t    cmd;
    ptf_status_t status;

    logic [VA_W-1:0]    out_pa;
    logic [PAGE_W-1:0]  out_page;
    logic [FRAME_W-1:0] out_frame;
    logic               out_hit;
    logic               out_replaced;
    logic [PAGE_W-1:0]  out_evicted;
    logic               out_err;
    logic [CNT_W-1:0]   out_hits;
    logic [CNT_W-1:0]   out_misses;

    ptf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ptf_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_va        (s_tdata[VA_W-1:0]),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_pa       (out_pa),
        .out_page     (out_page),
        .out_frame    (out_frame),
        .out_hit      (out_hit),
        .out_replaced (out_replaced),
        .out_evicted  (out_evicted),
        .out_err      (out_err),
        .out_hits     (out_hits),
        .out_misses   (out_misses)
    );

    assign m_tdata = {{(M_DATA_W-M_RAW_W){1'b0}}, out_misses, out_hits, out_evicted,
                      out_frame, out_page, out_pa};
    assign m_tuser = {out_err, out_replaced, out_hit};

endmodule

// File: tb/tb_page_translate_fifo_replace_core.sv
// Testbench for page_translate_fifo_replace_core: random and directed address
// stream checked against a built-in page table / FIFO frame predictor.
// Depends on ptf_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_page_translate_fifo_replace_core;
    import ptf_pkg::*;

    localparam int LIMIT        = 400000;
    localparam int PHASES       = 14;
    localparam int PHASE_ITEMS  = 82;
    localparam int SETTLE       = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = CFG_IDX_W'(3);

    typedef struct {
        logic [VA_W-1:0]    phys_addr;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        logic               hit;
        logic               replaced;
        logic [PAGE_W-1:0]  evicted;
        logic               range_err;
        logic [CNT_W-1:0]   hits;
        logic [CNT_W-1:0]   misses;
    } xlate_result_t;

    // Page table with round-robin frame reuse; holds the expected translations
    class page_xlate_board;
        xlate_result_t      due[$];
        bit                 mapped[MAX_PAGES];
        logic [FRAME_W-1:0] map_frame[MAX_PAGES];
        logic [PAGE_W-1:0]  owner[MAX_FRAMES];
        int unsigned        frames_taken;
        int unsigned        fifo_head;
        logic [CNT_W-1:0]   hit_cnt;
        logic [CNT_W-1:0]   miss_cnt;
        logic [PB_W-1:0]    reg_pb;
        logic [VB_W-1:0]    reg_vb;
        logic [PHB_W-1:0]   reg_phb;
        int                 errors;

        function new();
            foreach (mapped[i]) mapped[i] = 1'b0;
            frames_taken = 0;
            fifo_head    = 0;
            hit_cnt      = '0;
            miss_cnt     = '0;
            reg_pb       = PB_RST;
            reg_vb       = VB_RST;
            reg_phb      = PHB_RST;
            errors       = 0;
        endfunction

        function int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function int unsigned span_of(int unsigned wide, int unsigned pb, int unsigned cap);
            int unsigned n;
            n = (wide > pb) ? (32'd1 << (wide - pb)) : 1;
            return (n > cap) ? cap : n;
        endfunction

        function int unsigned page_shift();
            return clamp_to(reg_pb, 1, 12);
        endfunction

        function int unsigned va_width();
            return clamp_to(reg_vb, 2, 20);
        endfunction

        function int unsigned page_span();
            return span_of(va_width(), page_shift(), MAX_PAGES);
        endfunction

        function int unsigned frame_span();
            return span_of(clamp_to(reg_phb, 1, 20), page_shift(), MAX_FRAMES);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_PAGE_BITS:     reg_pb  = val[PB_W-1:0];
                CFG_VIRTUAL_BITS:  reg_vb  = val[VB_W-1:0];
                CFG_PHYSICAL_BITS: reg_phb = val[PHB_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void note_request(logic [VA_W-1:0] va);
            xlate_result_t r;
            int unsigned   pb, vb, pages, frames, pg, off, fr, ev;
            pb     = page_shift();
            vb     = va_width();
            pages  = page_span();
            frames = frame_span();
            pg     = va >> pb;
            off    = va & ((32'd1 << pb) - 1);
            r      = '{default: '0};
            if ((va >> vb) != 0 || pg >= pages) begin
                // out of range: nothing moves, counters reported as they stand
                r.range_err = 1'b1;
            end else begin
                if (mapped[pg]) begin
                    r.hit   = 1'b1;
                    fr      = map_frame[pg];
                    hit_cnt = hit_cnt + 1;
                end else begin
                    miss_cnt = miss_cnt + 1;
                    if (frames_taken >= frames) begin
                        // table full (or frame count shrank): evict oldest
                        if (fifo_head >= frames) fifo_head = 0;
                        fr          = fifo_head;
                        ev          = owner[fr];
                        mapped[ev]  = 1'b0;
                        r.replaced  = 1'b1;
                        r.evicted   = PAGE_W'(ev);
                        fifo_head   = (fr + 1 >= frames) ? 0 : fr + 1;
                    end else begin
                        fr           = frames_taken;
                        frames_taken = frames_taken + 1;
                    end
                    mapped[pg]    = 1'b1;
                    map_frame[pg] = FRAME_W'(fr);
                    owner[fr]     = PAGE_W'(pg);
                end
                r.phys_addr = VA_W'((fr << pb) + off);
                r.page      = PAGE_W'(pg);
                r.frame     = FRAME_W'(fr);
            end
            r.hits   = hit_cnt;
            r.misses = miss_cnt;
            due      = {due, r};
        endfunction

        function void cmp_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                         want, got);
            end
        endfunction

        function void check_result(logic [M_DATA_W-1:0] tdata, logic [M_USER_W-1:0] tuser);
            xlate_result_t want;
            if (due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %0h/%0h",
                         $time, tdata, tuser);
                return;
            end
            want = due.pop_front();
            cmp_field("physical_address", want.phys_addr, tdata[19:0]);
            cmp_field("page_number",      want.page,      tdata[31:20]);
            cmp_field("frame_number",     want.frame,     tdata[39:32]);
            cmp_field("evicted_page",     want.evicted,   tdata[51:40]);
            cmp_field("hit_count",        want.hits,      tdata[83:52]);
            cmp_field("miss_count",       want.misses,    tdata[115:84]);
            cmp_field("hit",              want.hit,       tuser[0]);
            cmp_field("replaced",         want.replaced,  tuser[1]);
            cmp_field("range_error",      want.range_err, tuser[2]);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;    // virtual_address
    logic                  m_tvalid;
    logic                  m_tready;
    // physical_address, page_number, frame_number, evicted_page, hit_count, miss_count
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;    // hit, replaced, range_error

    page_xlate_board board;
    bit              quiet;
    int unsigned     work_base;
    int              cycles;

    page_translate_fifo_replace_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(negedge aclk) begin
        m_tready <= quiet || ($urandom_range(0, 99) >= 12);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[page_translate_fifo_replace_core] ERROR");
            $finish;
        end
    end

    task automatic send_va(input logic [VA_W-1:0] va);
        while (!quiet && $urandom_range(0, 99) < 12) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(va);
        do @(posedge aclk); while (!s_tready);
        board.note_request(va);
    endtask

    // hold off input until every translation is back, then let the core settle
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        board.write_reg(idx, val);
    endtask

    // mostly pages from a working set a bit larger than the frame pool
    function automatic logic [VA_W-1:0] pick_address();
        int unsigned pb, vb, pages, frames, ws, pg, roll;
        logic [VA_W-1:0] va;
        pb     = board.page_shift();
        vb     = board.va_width();
        pages  = board.page_span();
        frames = board.frame_span();
        roll   = $urandom_range(0, 99);
        va     = VA_W'($urandom);
        if (roll < 8) return va;
        if (roll < 13 && vb < VA_W) return va | VA_W'(32'd1 << vb);
        ws = frames + frames / 2 + 2;
        if (ws > pages) ws = pages;
        pg = (work_base + $urandom_range(0, ws - 1)) % pages;
        va = VA_W'((pg << pb) | ($urandom & ((32'd1 << pb) - 1)));
        return va & VA_W'((32'd1 << vb) - 1);
    endfunction

    int fix_pb  [7] = '{8, 12, 1, 12, 1, 16, 15};
    int fix_vb  [7] = '{16, 20, 2, 20, 20, 31, 1};
    int fix_phb [7] = '{10, 20, 1, 12, 20, 0, 31};

    initial begin
        logic [VA_W-1:0] seq[$];
        int pb, vb, phb;
        board     = new();
        quiet     = 1'b0;
        work_base = 0;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset config: 256 pages of 256 bytes, 16 frames
        seq = '{20'h00000, 20'h000FF, 20'hFFFFF, 20'h10000, 20'h0FFFF};
        for (int p = 1; p <= 14; p++) seq = {seq, VA_W'(p << 8) | VA_W'(p)};
        seq = {seq, 20'h01400};   // table full: evicts the first page loaded
        seq = {seq, 20'h00000};   // page 0 back in, evicting page 255
        seq = {seq, 20'h0FF80};
        seq = {seq, 20'h00233};   // hit
        seq = {seq, 20'h0FF00};
        foreach (seq[i]) send_va(seq[i]);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 7) begin
                pb  = fix_pb[ph];
                vb  = fix_vb[ph];
                phb = fix_phb[ph];
            end else if ($urandom_range(0, 3) == 0) begin
                pb  = $urandom_range(0, 31);
                vb  = $urandom_range(0, 31);
                phb = $urandom_range(0, 31);
            end else begin
                pb  = $urandom_range(1, 12);
                vb  = $urandom_range(pb, 20);
                phb = $urandom_range(1, 20);
            end
            cfg_write(CFG_PAGE_BITS, CFG_DATA_W'(pb));
            cfg_write(CFG_VIRTUAL_BITS, CFG_DATA_W'(vb));
            cfg_write(CFG_PHYSICAL_BITS, CFG_DATA_W'(phb));
            if (ph == 2) cfg_write(CFG_UNUSED_IDX, CFG_DATA_W'(31));
            work_base = $urandom_range(0, board.page_span() - 1);
            quiet     = (ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_va(pick_address());
                if (ph == 5 && n == PHASE_ITEMS / 2) drain();
            end
            drain();
        end
        quiet = 1'b0;

        repeat (20) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("[page_translate_fifo_replace_core] OK");
        end else begin
            $display("[page_translate_fifo_replace_core] ERROR");
        end
        $finish;
    end

endmodule
